### hdl/elf_lsc_pkg.sv
// Shared types and constants for the ELF load segment checker.
package elf_lsc_pkg;

    localparam int unsigned PHDR_BYTES = 56;
    localparam logic [31:0] TYPE_LOAD  = 32'd1;
    localparam int unsigned SEED_W     = 26;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SIZE  = 3'd1,
        ST_WRAP  = 3'd2,
        ST_IMAGE = 3'd3,
        ST_RESV  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_TABLE_OFFSET  = 3'd0,
        REG_HEADER_COUNT  = 3'd1,
        REG_RESERVED_BASE = 3'd2,
        REG_RESERVED_SIZE = 3'd3,
        REG_IMAGE_LIMIT   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [31:0] seg_type;
        logic [63:0] file_offset;
        logic [63:0] file_size;
        logic [63:0] mem_size;
        logic [63:0] phys_addr;
        logic [63:0] virt_addr;
    } phdr_t;

    // Settings seen by the checker, with derived values registered
    typedef struct packed {
        logic [SEED_W-1:0] extent_seed;
        logic [63:0]       reserved_base;
        logic [63:0]       reserved_size;
        logic [63:0]       reserved_end;
        logic              reserved_wrap;
        logic [63:0]       image_limit;
    } cfg_t;

endpackage

### hdl/elf_lsc_cfg.sv
// Configuration registers and values derived from them.
module elf_lsc_cfg #(
    parameter int MAX_HEADERS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output elf_lsc_pkg::cfg_t   cfg
);

    logic [24:0] table_offset_reg;
    logic [5:0]  header_count_reg;
    logic [63:0] reserved_base_reg;
    logic [63:0] reserved_size_reg;
    logic [63:0] image_limit_reg;
    logic [elf_lsc_pkg::SEED_W-1:0] seed_reg;
    logic [63:0] resv_end_reg;
    logic        resv_wrap_reg;

    logic [5:0]  count_sat;
    logic [elf_lsc_pkg::SEED_W-1:0] seed_next;
    logic [64:0] resv_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_offset_reg  <= 25'd64;
            header_count_reg  <= 6'd1;
            reserved_base_reg <= 64'd0;
            reserved_size_reg <= 64'd0;
            image_limit_reg   <= 64'd16777216;
        end else if (cfg_valid) begin
            case (elf_lsc_pkg::reg_index_t'(cfg_index))
                elf_lsc_pkg::REG_TABLE_OFFSET:  table_offset_reg  <= cfg_data[24:0];
                elf_lsc_pkg::REG_HEADER_COUNT:  header_count_reg  <= cfg_data[5:0];
                elf_lsc_pkg::REG_RESERVED_BASE: reserved_base_reg <= cfg_data;
                elf_lsc_pkg::REG_RESERVED_SIZE: reserved_size_reg <= cfg_data;
                elf_lsc_pkg::REG_IMAGE_LIMIT:   image_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate the header count; a limit above 63 never bites
    always_comb begin
        if (int'(header_count_reg) > MAX_HEADERS) begin
            count_sat = MAX_HEADERS[5:0];
        end else begin
            count_sat = header_count_reg;
        end
        seed_next = elf_lsc_pkg::SEED_W'(table_offset_reg)
                  + elf_lsc_pkg::SEED_W'(count_sat) * elf_lsc_pkg::SEED_W'(elf_lsc_pkg::PHDR_BYTES);
        resv_sum  = {1'b0, reserved_base_reg} + {1'b0, reserved_size_reg};
    end

    // Derived values are registered and settle in the cycle after the registers
    always_ff @(posedge aclk) begin
        seed_reg      <= seed_next;
        resv_end_reg  <= resv_sum[63:0];
        resv_wrap_reg <= resv_sum[64];
    end

    assign cfg.extent_seed   = seed_reg;
    assign cfg.reserved_base = reserved_base_reg;
    assign cfg.reserved_size = reserved_size_reg;
    assign cfg.reserved_end  = resv_end_reg;
    assign cfg.reserved_wrap = resv_wrap_reg;
    assign cfg.image_limit   = image_limit_reg;

endmodule

### hdl/elf_lsc_check.sv
// Checks of one program header and the next sticky state.
module elf_lsc_check (
    input  elf_lsc_pkg::phdr_t    hdr,
    input  elf_lsc_pkg::cfg_t     cfg,
    input  logic                  failed_in,
    input  logic [63:0]           extent_in,
    output elf_lsc_pkg::status_t  status,
    output logic                  failed_out,
    output logic [63:0]           extent_out
);

    logic [63:0] target;
    logic [64:0] seg_sum;
    logic [64:0] file_sum;
    logic        size_bad;
    logic        wrap_bad;
    logic        image_bad;
    logic        resv_bad;
    elf_lsc_pkg::status_t verdict;

    always_comb begin
        target    = (hdr.phys_addr != 64'd0) ? hdr.phys_addr : hdr.virt_addr;
        seg_sum   = {1'b0, target} + {1'b0, hdr.mem_size};
        file_sum  = {1'b0, hdr.file_offset} + {1'b0, hdr.file_size};
        size_bad  = hdr.mem_size < hdr.file_size;
        wrap_bad  = seg_sum[64] | file_sum[64];
        image_bad = file_sum[63:0] > cfg.image_limit;

        // Empty ranges never meet; a wrapping range meets everything
        if (hdr.mem_size == 64'd0 || cfg.reserved_size == 64'd0) begin
            resv_bad = 1'b0;
        end else if (seg_sum[64] || cfg.reserved_wrap) begin
            resv_bad = 1'b1;
        end else begin
            resv_bad = !(seg_sum[63:0] <= cfg.reserved_base
                         || cfg.reserved_end <= target);
        end

        if (size_bad) begin
            verdict = elf_lsc_pkg::ST_SIZE;
        end else if (wrap_bad) begin
            verdict = elf_lsc_pkg::ST_WRAP;
        end else if (image_bad) begin
            verdict = elf_lsc_pkg::ST_IMAGE;
        end else if (resv_bad) begin
            verdict = elf_lsc_pkg::ST_RESV;
        end else begin
            verdict = elf_lsc_pkg::ST_OK;
        end

        status     = elf_lsc_pkg::ST_OK;
        failed_out = failed_in;
        extent_out = extent_in;
        if (!failed_in && hdr.seg_type == elf_lsc_pkg::TYPE_LOAD) begin
            status = verdict;
            if (verdict != elf_lsc_pkg::ST_OK) begin
                failed_out = 1'b1;
            end else if (file_sum[63:0] > extent_in) begin
                extent_out = file_sum[63:0];
            end
        end
    end

endmodule

### hdl/elf_load_segment_checker.sv
// Top level: ELF64 program header checker with input and result registers.
//
// Takes one ELF64 program header per item and returns one verdict per item.
// Each item is held in the input register and is checked in the cycle it
// moves to the result register, so a new item is taken every cycle unless
// the result register is full and m_tready is low; the verdict stays in
// the result register until taken. The sticky failure flag and highest file
// extent update as each item moves to the result register, so back-to-back
// headers see their predecessor's state. Configuration writes are accepted
// in the cycle they are offered; derived values (table end seed, reserved
// region end) settle in the cycle after the written registers do.
module elf_load_segment_checker #(
    parameter int MAX_HEADERS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    // configuration write channel
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    // header items
    input  logic          s_tvalid,
    output logic          s_tready,
    // seg_type[31:0], file_offset[95:32], file_size[159:96], mem_size[223:160],
    // phys_addr[287:224], virt_addr[351:288]
    input  logic [351:0]  s_tdata,
    // first[0]
    input  logic [0:0]    s_tuser,
    input  logic          s_tlast,
    // verdict items
    output logic          m_tvalid,
    input  logic          m_tready,
    // item_status[2:0], failed[3], highest_extent[67:4], zero fill [71:68]
    output logic [71:0]   m_tdata,
    output logic          m_tlast
);

    elf_lsc_pkg::cfg_t    cfg;
    elf_lsc_pkg::phdr_t   hdr_reg;
    logic                 in_valid_reg;
    logic                 in_first_reg;
    logic                 in_last_reg;

    logic                 fail_reg;
    logic [63:0]          extent_reg;

    logic                 out_valid_reg;
    elf_lsc_pkg::status_t out_status_reg;
    logic                 out_failed_reg;
    logic [63:0]          out_extent_reg;
    logic                 out_last_reg;

    logic                 advance;
    logic                 fire;
    logic                 failed_eff;
    logic [63:0]          extent_eff;
    elf_lsc_pkg::status_t status_next;
    logic                 fail_next;
    logic [63:0]          extent_next;

    elf_lsc_cfg #(
        .MAX_HEADERS (MAX_HEADERS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // First header clears failure and seeds the extent from the table end
    assign failed_eff = in_first_reg ? 1'b0 : fail_reg;
    assign extent_eff = in_first_reg ? 64'(cfg.extent_seed) : extent_reg;

    elf_lsc_check u_check (
        .hdr        (hdr_reg),
        .cfg        (cfg),
        .failed_in  (failed_eff),
        .extent_in  (extent_eff),
        .status     (status_next),
        .failed_out (fail_next),
        .extent_out (extent_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            hdr_reg      <= elf_lsc_pkg::phdr_t'({s_tdata[31:0], s_tdata[95:32],
                                                  s_tdata[159:96], s_tdata[223:160],
                                                  s_tdata[287:224], s_tdata[351:288]});
            in_first_reg <= s_tuser[0];
            in_last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_reg      <= 1'b0;
            extent_reg    <= 64'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                fail_reg   <= fail_next;
                extent_reg <= extent_next;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_status_reg <= status_next;
            out_failed_reg <= fail_next;
            out_extent_reg <= extent_next;
            out_last_reg   <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_extent_reg, out_failed_reg, 3'(out_status_reg)};
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    // A failing verdict always carries the sticky flag
    a_status_sets_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != elf_lsc_pkg::ST_OK) |-> out_failed_reg)
        else $error("failing item without failed flag");

    // Extent is frozen while failed until the next first header
    a_extent_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !in_first_reg && fail_reg) |=> (extent_reg == $past(extent_reg)))
        else $error("extent moved after failure");

    // Failure only rises when an item is checked
    a_fail_on_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fail_reg) |-> $past(fire))
        else $error("failure set without an item");

    // Input stalls only when the input register holds an item
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");
`endif

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the ELF64 program header checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_HDRS = 32;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam logic [31:0] TYPE_NULL = 32'd0;
    localparam logic [31:0] TYPE_DYNAMIC = 32'd2;
    localparam logic [31:0] TYPE_NOTE = 32'd4;
    localparam logic [31:0] TYPE_GNU_STACK = 32'h6474_E551;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 110;

    typedef struct {
        logic  first;
        logic  last;
        elf_lsc_pkg::phdr_t ph;
    } hdr_item_t;

    typedef struct {
        elf_lsc_pkg::status_t status;
        logic        failed;
        logic [63:0] extent;
        logic        last;
    } verdict_t;

    logic          aclk;
    logic          aresetn = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [63:0]   cfg_data = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [351:0]  s_tdata = '0;
    logic [0:0]    s_tuser = '0;
    logic          s_tlast = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [71:0]   m_tdata;
    logic          m_tlast;

    // checker state and register copies
    logic [24:0]   tbl_offset = 25'd64;
    logic [5:0]    hdr_count = 6'd1;
    logic [63:0]   resv_base = '0;
    logic [63:0]   resv_size = '0;
    logic [63:0]   img_limit = 64'd16777216;
    logic [63:0]   ext_max = '0;
    logic          fail_sticky = 1'b0;

    hdr_item_t     hdr_q[$];
    verdict_t      verdict_q[$];
    hdr_item_t     cur_hdr;
    int            mismatch_cnt = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    bit            src_burst = 1'b0;
    bit            sink_burst = 1'b0;
    bit            pressure_arm = 1'b0;
    logic          hold_sink = 1'b0;

    elf_load_segment_checker #(.MAX_HEADERS(MAX_HDRS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic verdict_t judge_header(input hdr_item_t it);
        verdict_t    v;
        logic [63:0] tgt;
        logic [63:0] mem_end;
        logic [63:0] file_end;
        logic [63:0] resv_end;
        logic [6:0]  cnt;
        elf_lsc_pkg::status_t st;
        st = elf_lsc_pkg::ST_OK;
        if (it.first) begin
            cnt = (hdr_count > MAX_HDRS) ? 7'(MAX_HDRS) : {1'b0, hdr_count};
            fail_sticky = 1'b0;
            ext_max = 64'(tbl_offset) + 64'(cnt) * 64'(elf_lsc_pkg::PHDR_BYTES);
        end
        if (!fail_sticky && it.ph.seg_type == elf_lsc_pkg::TYPE_LOAD) begin
            tgt = (it.ph.phys_addr != '0) ? it.ph.phys_addr : it.ph.virt_addr;
            mem_end = tgt + it.ph.mem_size;
            file_end = it.ph.file_offset + it.ph.file_size;
            resv_end = resv_base + resv_size;
            if (it.ph.mem_size < it.ph.file_size) begin
                st = elf_lsc_pkg::ST_SIZE;
            end else if (mem_end < tgt || file_end < it.ph.file_offset) begin
                st = elf_lsc_pkg::ST_WRAP;
            end else if (file_end > img_limit) begin
                st = elf_lsc_pkg::ST_IMAGE;
            end else if (it.ph.mem_size != '0 && resv_size != '0 &&
                         (resv_end < resv_base ||
                          !(mem_end <= resv_base || resv_end <= tgt))) begin
                st = elf_lsc_pkg::ST_RESV;
            end
            if (st != elf_lsc_pkg::ST_OK) fail_sticky = 1'b1;
            else if (file_end > ext_max) ext_max = file_end;
        end
        v.status = st;
        v.failed = fail_sticky;
        v.extent = ext_max;
        v.last = it.last;
        return v;
    endfunction

    // header driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) verdict_q.push_back(judge_header(cur_hdr));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (hdr_q.size() > 0) begin
                    cur_hdr = hdr_q.pop_front();
                    s_tdata <= {cur_hdr.ph.virt_addr, cur_hdr.ph.phys_addr,
                                cur_hdr.ph.mem_size, cur_hdr.ph.file_size,
                                cur_hdr.ph.file_offset, cur_hdr.ph.seg_type};
                    s_tuser <= cur_hdr.first;
                    s_tlast <= cur_hdr.last;
                    s_tvalid <= 1'b1;
                    if (!src_burst && $urandom_range(0, 2) == 0) gap_left = rand_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if ($urandom_range(0, 149) == 0) src_burst = !src_burst;
        end
    end

    // verdict monitor
    always @(posedge aclk) begin
        verdict_t want;
        logic     rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("verdict item with no expectation pending");
                    mismatch_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[2:0] !== want.status) begin
                        $error("item_status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                        mismatch_cnt++;
                    end
                    if (m_tdata[3] !== want.failed) begin
                        $error("failed: expected %0b, got %0b", want.failed, m_tdata[3]);
                        mismatch_cnt++;
                    end
                    if (m_tdata[67:4] !== want.extent) begin
                        $error("highest_extent: expected %h, got %h", want.extent,
                               m_tdata[67:4]);
                        mismatch_cnt++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_out: expected %0b, got %0b", want.last, m_tlast);
                        mismatch_cnt++;
                    end
                end
            end
            if (hold_sink) begin
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (!sink_burst && $urandom_range(0, 3) == 0) stall_left = rand_gap();
            end
            if ($urandom_range(0, 199) == 0) sink_burst = !sink_burst;
            m_tready <= rdy;
        end
    end

    // long receiver hold-off so the checker fills and stalls its input
    initial begin
        wait (pressure_arm);
        repeat ($urandom_range(20, 80)) @(posedge aclk);
        hold_sink <= 1'b1;
        repeat (500) @(posedge aclk);
        hold_sink <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("elf_load_segment_checker test failed");
        $finish;
    end

    task automatic push_hdr(input logic first, input logic last, input logic [31:0] typ,
                            input logic [63:0] foff, input logic [63:0] fsz,
                            input logic [63:0] msz, input logic [63:0] pa,
                            input logic [63:0] va);
        hdr_item_t it;
        it.first = first;
        it.last = last;
        it.ph.seg_type = typ;
        it.ph.file_offset = foff;
        it.ph.file_size = fsz;
        it.ph.mem_size = msz;
        it.ph.phys_addr = pa;
        it.ph.virt_addr = va;
        hdr_q.push_back(it);
    endtask

    // valid stays high across back-to-back writes; end_writes drops it
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            elf_lsc_pkg::REG_TABLE_OFFSET:  tbl_offset = val[24:0];
            elf_lsc_pkg::REG_HEADER_COUNT:  hdr_count = val[5:0];
            elf_lsc_pkg::REG_RESERVED_BASE: resv_base = val;
            elf_lsc_pkg::REG_RESERVED_SIZE: resv_size = val;
            elf_lsc_pkg::REG_IMAGE_LIMIT:   img_limit = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
        repeat (4) @(posedge aclk);
    endtask

    task automatic quiesce();
        do @(posedge aclk); while (hdr_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic rand_setting();
        logic [63:0] v;
        case ($urandom_range(0, 3))
            0: v = '0;
            1: v = 64'h1FF_FFFF;
            2: v = 64'($urandom_range(0, 4096));
            default: v = rand64();
        endcase
        write_reg(elf_lsc_pkg::REG_TABLE_OFFSET, v);
        case ($urandom_range(0, 3))
            0: v = '0;
            1: v = 64'd63;
            2: v = 64'($urandom_range(1, 32));
            default: v = rand64();
        endcase
        write_reg(elf_lsc_pkg::REG_HEADER_COUNT, v);
        case ($urandom_range(0, 3))
            0: v = '0;
            1: v = ALL_ONES;
            2: v = rand64();
            default: v = {32'd0, $urandom};
        endcase
        write_reg(elf_lsc_pkg::REG_RESERVED_BASE, v);
        case ($urandom_range(0, 7))
            0, 1: v = '0;
            2: v = ALL_ONES;
            3: v = rand64();
            default: v = 64'($urandom_range(1, 1 << 20));
        endcase
        write_reg(elf_lsc_pkg::REG_RESERVED_SIZE, v);
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = ALL_ONES;
            2, 3: v = 64'd16777216;
            4: v = 64'($urandom_range(0, 1 << 20));
            default: v = rand64();
        endcase
        write_reg(elf_lsc_pkg::REG_IMAGE_LIMIT, v);
        if ($urandom_range(0, 3) == 0)
            write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), rand64());
        end_writes();
    endtask

    function automatic logic [63:0] near_reserved();
        return resv_base + 64'($urandom_range(0, 8192)) - 64'd4096;
    endfunction

    // one well-formed table of headers with random content
    task automatic gen_table(output int n);
        hdr_item_t it;
        int        r;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            it.first = (i == 0);
            it.last = (i == n - 1);
            if ($urandom_range(0, 99) < 65) begin
                it.ph.seg_type = elf_lsc_pkg::TYPE_LOAD;
            end else begin
                case ($urandom_range(0, 4))
                    0: it.ph.seg_type = TYPE_NULL;
                    1: it.ph.seg_type = TYPE_DYNAMIC;
                    2: it.ph.seg_type = TYPE_NOTE;
                    3: it.ph.seg_type = TYPE_GNU_STACK;
                    default: it.ph.seg_type = $urandom;
                endcase
            end
            it.ph.file_offset = ($urandom_range(0, 99) < 85) ?
                                64'($urandom_range(0, (1 << 20) - 1)) : rand64();
            it.ph.file_size = ($urandom_range(0, 99) < 85) ?
                              64'($urandom_range(0, 65535)) : rand64();
            r = $urandom_range(0, 99);
            if (r < 75) it.ph.mem_size = it.ph.file_size + 64'($urandom_range(0, 4096));
            else if (r < 85) it.ph.mem_size = '0;
            else if (r < 92) it.ph.mem_size = rand64();
            else it.ph.mem_size = it.ph.file_size - 64'd1;
            r = $urandom_range(0, 99);
            if (r < 20) it.ph.phys_addr = '0;
            else if (r < 35) it.ph.phys_addr = near_reserved();
            else it.ph.phys_addr = rand64();
            it.ph.virt_addr = ($urandom_range(0, 3) == 0) ? near_reserved() : rand64();
            hdr_q.push_back(it);
        end
    endtask

    task automatic push_noise();
        push_hdr(1'($urandom), 1'($urandom), $urandom, rand64(), rand64(), rand64(),
                 rand64(), rand64());
    endtask

    initial begin
        int pushed;
        int n;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings; the first item runs before any first header
        push_hdr(1'b0, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h10, 64'h20, 64'h1000,
                 64'h0);
        push_hdr(1'b1, 1'b0, ALL_ONES[31:0], ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                 ALL_ONES);
        push_hdr(1'b0, 1'b0, TYPE_NULL, '0, '0, '0, '0, '0);
        push_hdr(1'b0, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h100, 64'h200, 64'h200, 64'h0,
                 64'h2000);
        push_hdr(1'b0, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h10, 64'hF, 64'h4000,
                 64'h0);
        // failure is sticky: a good header now is not checked
        push_hdr(1'b0, 1'b1, elf_lsc_pkg::TYPE_LOAD, 64'h400, 64'h10, 64'h10, 64'h5000,
                 64'h0);
        push_hdr(1'b1, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h0, 64'h1, ALL_ONES,
                 64'h0);
        push_hdr(1'b1, 1'b0, elf_lsc_pkg::TYPE_LOAD, ALL_ONES, 64'h1, 64'h1, 64'h10,
                 64'h0);
        push_hdr(1'b1, 1'b1, elf_lsc_pkg::TYPE_LOAD, 64'd16777215, 64'h1, 64'h1, 64'h10,
                 64'h0);
        push_hdr(1'b1, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'd16777216, 64'h1, 64'h1, 64'h10,
                 64'h0);
        push_hdr(1'b1, 1'b1, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);

        quiesce();
        write_reg(elf_lsc_pkg::REG_TABLE_OFFSET, ALL_ONES);
        write_reg(elf_lsc_pkg::REG_HEADER_COUNT, 64'd63);
        write_reg(elf_lsc_pkg::REG_RESERVED_BASE, 64'h8000_0000);
        write_reg(elf_lsc_pkg::REG_RESERVED_SIZE, 64'h1000);
        write_reg(elf_lsc_pkg::REG_IMAGE_LIMIT, ALL_ONES);
        end_writes();
        // reserved region edges: touching below, touching above, last byte inside
        push_hdr(1'b1, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h0, 64'h100,
                 64'h7FFF_FF00, 64'h0);
        push_hdr(1'b0, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h0, 64'h10,
                 64'h8000_1000, 64'h0);
        push_hdr(1'b0, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h0, 64'h1,
                 64'h8000_0FFF, 64'h0);
        push_hdr(1'b1, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h0, 64'h0,
                 64'h8000_0800, 64'h0);
        push_hdr(1'b0, 1'b1, elf_lsc_pkg::TYPE_LOAD, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF,
                 64'hFFFF, 64'h10, 64'h0);
        push_hdr(1'b1, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h0, 64'h2,
                 64'h7FFF_FFFF, 64'h0);

        quiesce();
        write_reg(elf_lsc_pkg::REG_TABLE_OFFSET, 64'h0);
        write_reg(elf_lsc_pkg::REG_HEADER_COUNT, 64'h0);
        write_reg(elf_lsc_pkg::REG_RESERVED_BASE, ALL_ONES - 64'd1);
        write_reg(elf_lsc_pkg::REG_RESERVED_SIZE, 64'h2);
        write_reg(elf_lsc_pkg::REG_IMAGE_LIMIT, 64'h0);
        write_reg(REG_SPARE_HI, rand64());
        end_writes();
        // wrapping reserved region catches any nonempty target
        push_hdr(1'b1, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h0, 64'h1, 64'h10, 64'h0);
        push_hdr(1'b1, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h0, 64'h0, 64'h10, 64'h0);
        push_hdr(1'b1, 1'b0, elf_lsc_pkg::TYPE_LOAD, 64'h0, 64'h1, 64'h1, 64'h10, 64'h0);
        push_hdr(1'b1, 1'b1, TYPE_GNU_STACK, 64'h0, 64'h1, 64'h0, 64'h0, 64'h0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            quiesce();
            rand_setting();
            pressure_arm = 1'b1;
            pushed = 0;
            while (pushed < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_noise();
                    pushed++;
                end else begin
                    gen_table(n);
                    pushed += n;
                end
            end
        end

        do @(posedge aclk); while (hdr_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("elf_load_segment_checker test passed");
        end else begin
            $display("elf_load_segment_checker test failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/elf_lsc_pkg.sv
hdl/elf_lsc_cfg.sv
hdl/elf_lsc_check.sv
hdl/elf_load_segment_checker.sv
tb/sv/tb_top.sv
